// ===== rtl/hcp_pkg.sv =====
// Shared constants for the harmonic complex power block.
package hcp_pkg;

    localparam int SAMPLE_BITS_DEFAULT = 24;
    localparam int POWER_W             = 48;
    localparam int APPARENT_W          = 47;

endpackage

// ===== rtl/hcp_isqrt.sv =====
// Pipelined floor square root, one root bit per register stage, with sideband.
module hcp_isqrt #(
    parameter int RAD_W  = 94,
    parameter int SIDE_W = 97
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              enable,
    input  logic              rad_valid,
    input  logic [RAD_W-1:0]  rad,
    input  logic [SIDE_W-1:0] rad_side,
    output logic              root_valid,
    output logic [RAD_W/2-1:0] root,
    output logic [SIDE_W-1:0] root_side
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    logic              v_reg    [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [SIDE_W-1:0] side_reg [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W-1];
    logic [RAD_W-1:0]  rad_reg  [ROOT_W-1];

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_stage
        logic              v_cur;
        logic [RAD_W-1:0]  rad_cur;
        logic [REM_W-1:0]  rem_cur;
        logic [ROOT_W-1:0] root_cur;
        logic [SIDE_W-1:0] side_cur;
        logic [REM_W-1:0]  rem4;
        logic [REM_W-1:0]  trial;
        logic              ge;

        if (k == 0)
        begin : g_first
            assign v_cur    = rad_valid;
            assign rad_cur  = rad;
            assign rem_cur  = '0;
            assign root_cur = '0;
            assign side_cur = rad_side;
        end
        else
        begin : g_next
            assign v_cur    = v_reg[k-1];
            assign rad_cur  = rad_reg[k-1];
            assign rem_cur  = rem_reg[k-1];
            assign root_cur = root_reg[k-1];
            assign side_cur = side_reg[k-1];
        end

        // rem stays below 2*root+1, so its top two bits are always zero here
        assign rem4  = {rem_cur[REM_W-3:0], rad_cur[RAD_W-1:RAD_W-2]};
        assign trial = {root_cur, 2'b01};
        assign ge    = (rem4 >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (enable)
            begin
                v_reg[k] <= v_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (enable)
            begin
                root_reg[k] <= {root_cur[ROOT_W-2:0], ge};
                side_reg[k] <= side_cur;
            end
        end

        if (k < ROOT_W - 1)
        begin : g_keep
            always_ff @(posedge clk)
            begin
                if (enable)
                begin
                    rem_reg[k] <= ge ? (rem4 - trial) : rem4;
                    rad_reg[k] <= {rad_cur[RAD_W-3:0], 2'b00};
                end
            end
        end
    end

    assign root_valid = v_reg[ROOT_W-1];
    assign root       = root_reg[ROOT_W-1];
    assign root_side  = side_reg[ROOT_W-1];

endmodule

// ===== rtl/harmonic_complex_power.sv =====
// Top level: active, reactive and apparent power from voltage and current phasors.
// From transaction accept to result_valid a transaction passes through
// six arithmetic stages, one square root stage per root bit and one output register.
// Throughput: one transaction per cycle; the pipeline freezes only while the skid entry is full.
// Reset clears every valid bit, the output and skid flags included; data registers keep
// whatever they hold, and there is no other state.
module harmonic_complex_power #(
    parameter int SAMPLE_BITS = hcp_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                pair_valid,
    output logic                                pair_stall,
    input  logic signed [SAMPLE_BITS-1:0]       voltage_real,
    input  logic signed [SAMPLE_BITS-1:0]       voltage_imag,
    input  logic signed [SAMPLE_BITS-1:0]       current_real,
    input  logic signed [SAMPLE_BITS-1:0]       current_imag,
    input  logic                                last_pair,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [hcp_pkg::POWER_W-1:0]  active_power,
    output logic signed [hcp_pkg::POWER_W-1:0]  reactive_power,
    output logic [hcp_pkg::APPARENT_W-1:0]      apparent_power,
    output logic                                last_result
);

    localparam int OW     = hcp_pkg::POWER_W;
    localparam int AW     = hcp_pkg::APPARENT_W;
    localparam int PROD_W = 2 * SAMPLE_BITS;
    localparam int SUM_W  = PROD_W + 1;
    localparam int PW     = PROD_W;
    localparam int MW     = PROD_W - 1;
    localparam int LO_W   = SAMPLE_BITS;
    localparam int HI_W   = MW - LO_W;
    localparam int SQ_W   = 2 * MW;
    localparam int ROOT_W = SQ_W / 2;
    localparam int SIDE_W = 2 * OW + 1;

    logic enable;

    // stage 1: products
    logic                     v1_reg;
    logic                     last1_reg;
    logic signed [PROD_W-1:0] urir_reg;
    logic signed [PROD_W-1:0] uiii_reg;
    logic signed [PROD_W-1:0] urii_reg;
    logic signed [PROD_W-1:0] irui_reg;
    logic signed [PROD_W-1:0] urir_next;
    logic signed [PROD_W-1:0] uiii_next;
    logic signed [PROD_W-1:0] urii_next;
    logic signed [PROD_W-1:0] irui_next;

    // stage 2: halved sums
    logic                     v2_reg;
    logic                     last2_reg;
    logic signed [PW-1:0]     p2_reg;
    logic signed [PW-1:0]     q2_reg;
    logic signed [SUM_W-1:0]  p_sum;
    logic signed [SUM_W-1:0]  q_sum;

    // stage 3: magnitudes and saturated outputs
    logic                     v3_reg;
    logic [MW-1:0]            mag_p3_reg;
    logic [MW-1:0]            mag_q3_reg;
    logic [SIDE_W-1:0]        side3_reg;
    logic [PW-1:0]            neg_p;
    logic [PW-1:0]            neg_q;
    logic [OW-1:0]            p_sat;
    logic [OW-1:0]            q_sat;

    // stage 4: partial products of the squares
    logic                     v4_reg;
    logic [2*HI_W-1:0]        p_hh4_reg;
    logic [HI_W+LO_W-1:0]     p_hl4_reg;
    logic [2*LO_W-1:0]        p_ll4_reg;
    logic [2*HI_W-1:0]        q_hh4_reg;
    logic [HI_W+LO_W-1:0]     q_hl4_reg;
    logic [2*LO_W-1:0]        q_ll4_reg;
    logic [SIDE_W-1:0]        side4_reg;
    logic [HI_W-1:0]          p_hi;
    logic [LO_W-1:0]          p_lo;
    logic [HI_W-1:0]          q_hi;
    logic [LO_W-1:0]          q_lo;

    // stage 5: squares
    logic                     v5_reg;
    logic [SQ_W-1:0]          sq_p5_reg;
    logic [SQ_W-1:0]          sq_q5_reg;
    logic [SIDE_W-1:0]        side5_reg;

    // stage 6: sum of squares
    logic                     v6_reg;
    logic [SQ_W-1:0]          rad6_reg;
    logic [SIDE_W-1:0]        side6_reg;

    // square root and output
    logic                     root_valid;
    logic [ROOT_W-1:0]        root;
    logic [SIDE_W-1:0]        root_side;
    logic [AW-1:0]            apparent_fin;

    logic                     result_valid_reg;
    logic                     result_valid_next;
    logic                     skid_valid_reg;
    logic                     skid_valid_next;
    logic                     take;
    logic                     load_result;
    logic                     load_skid;
    logic                     from_skid;
    logic [SIDE_W-1:0]        result_side_reg;
    logic [AW-1:0]            result_apparent_reg;
    logic [SIDE_W-1:0]        skid_side_reg;
    logic [AW-1:0]            skid_apparent_reg;

    assign enable     = !skid_valid_reg;
    assign pair_stall = skid_valid_reg;

    // stage 1
    assign urir_next = voltage_real * current_real;
    assign uiii_next = voltage_imag * current_imag;
    assign urii_next = voltage_real * current_imag;
    assign irui_next = current_real * voltage_imag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (enable)
        begin
            v1_reg <= pair_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // stage 2: arithmetic shift gives floor of the half
    assign p_sum = SUM_W'(urir_reg) + SUM_W'(uiii_reg);
    assign q_sum = SUM_W'(urii_reg) - SUM_W'(irui_reg);

    // stage 3
    assign neg_p = -p2_reg;
    assign neg_q = -q2_reg;

    if (PW > OW)
    begin : g_sat
        always_comb
        begin
            if (&p2_reg[PW-1:OW-1] || ~|p2_reg[PW-1:OW-1])
            begin
                p_sat = p2_reg[OW-1:0];
            end
            else
            begin
                p_sat = {p2_reg[PW-1], {(OW-1){~p2_reg[PW-1]}}};
            end
            if (&q2_reg[PW-1:OW-1] || ~|q2_reg[PW-1:OW-1])
            begin
                q_sat = q2_reg[OW-1:0];
            end
            else
            begin
                q_sat = {q2_reg[PW-1], {(OW-1){~q2_reg[PW-1]}}};
            end
        end
    end
    else
    begin : g_ext
        assign p_sat = OW'(p2_reg);
        assign q_sat = OW'(q2_reg);
    end

    // stage 4: split each magnitude in halves to keep multipliers narrow
    assign p_hi = mag_p3_reg[MW-1:LO_W];
    assign p_lo = mag_p3_reg[LO_W-1:0];
    assign q_hi = mag_q3_reg[MW-1:LO_W];
    assign q_lo = mag_q3_reg[LO_W-1:0];

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            urir_reg   <= urir_next;
            uiii_reg   <= uiii_next;
            urii_reg   <= urii_next;
            irui_reg   <= irui_next;
            last1_reg  <= last_pair;

            p2_reg     <= p_sum[SUM_W-1:1];
            q2_reg     <= q_sum[SUM_W-1:1];
            last2_reg  <= last1_reg;

            mag_p3_reg <= p2_reg[PW-1] ? neg_p[MW-1:0] : p2_reg[MW-1:0];
            mag_q3_reg <= q2_reg[PW-1] ? neg_q[MW-1:0] : q2_reg[MW-1:0];
            side3_reg  <= {last2_reg, p_sat, q_sat};

            p_hh4_reg  <= p_hi * p_hi;
            p_hl4_reg  <= p_hi * p_lo;
            p_ll4_reg  <= p_lo * p_lo;
            q_hh4_reg  <= q_hi * q_hi;
            q_hl4_reg  <= q_hi * q_lo;
            q_ll4_reg  <= q_lo * q_lo;
            side4_reg  <= side3_reg;

            sq_p5_reg  <= (SQ_W'(p_hh4_reg) << (2 * LO_W))
                        + (SQ_W'(p_hl4_reg) << (LO_W + 1))
                        + SQ_W'(p_ll4_reg);
            sq_q5_reg  <= (SQ_W'(q_hh4_reg) << (2 * LO_W))
                        + (SQ_W'(q_hl4_reg) << (LO_W + 1))
                        + SQ_W'(q_ll4_reg);
            side5_reg  <= side4_reg;

            // sum of two squares stays below 2^(SQ_W-1)
            rad6_reg   <= sq_p5_reg + sq_q5_reg;
            side6_reg  <= side5_reg;
        end
    end

    hcp_isqrt #(
        .RAD_W  (SQ_W),
        .SIDE_W (SIDE_W)
    ) u_isqrt (
        .clk        (clk),
        .rst_n      (rst_n),
        .enable     (enable),
        .rad_valid  (v6_reg),
        .rad        (rad6_reg),
        .rad_side   (side6_reg),
        .root_valid (root_valid),
        .root       (root),
        .root_side  (root_side)
    );

    if (ROOT_W > AW)
    begin : g_root_sat
        assign apparent_fin = (|root[ROOT_W-1:AW]) ? '1 : root[AW-1:0];
    end
    else
    begin : g_root_ext
        assign apparent_fin = AW'(root);
    end

    // output register with one skid entry
    assign take = result_valid_reg && !result_stall;

    always_comb
    begin
        result_valid_next = result_valid_reg;
        skid_valid_next   = skid_valid_reg;
        load_result       = 1'b0;
        load_skid         = 1'b0;
        from_skid         = 1'b0;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                load_result     = 1'b1;
                from_skid       = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else
        begin
            if (take)
            begin
                result_valid_next = 1'b0;
            end
            if (root_valid)
            begin
                if (!result_valid_reg || take)
                begin
                    load_result       = 1'b1;
                    result_valid_next = 1'b1;
                end
                else
                begin
                    load_skid       = 1'b1;
                    skid_valid_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            skid_valid_reg   <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            result_side_reg     <= from_skid ? skid_side_reg : root_side;
            result_apparent_reg <= from_skid ? skid_apparent_reg : apparent_fin;
        end
        if (load_skid)
        begin
            skid_side_reg     <= root_side;
            skid_apparent_reg <= apparent_fin;
        end
    end

    assign result_valid   = result_valid_reg;
    assign last_result    = result_side_reg[SIDE_W-1];
    assign active_power   = result_side_reg[2*OW-1:OW];
    assign reactive_power = result_side_reg[OW-1:0];
    assign apparent_power = result_apparent_reg;

endmodule
